[src/tam_pkg.sv]
// ----------------------------------------------------------------------------
// tam_pkg
// Shared types and constants of the threshold alert monitor: item and
// statistics layouts, event codes, register addresses and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tam_pkg;

    // opcodes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_SUMMARY = 1'b1;

    // link states
    localparam logic [1:0] LINK_UNKNOWN = 2'd0;
    localparam logic [1:0] LINK_ONLINE  = 2'd1;
    localparam logic [1:0] LINK_DOWN    = 2'd2;
    // undefined code, handled like unknown
    localparam logic [1:0] LINK_INVALID = 2'd3;

    // event codes
    localparam logic [2:0] EV_DOWN        = 3'd0;
    localparam logic [2:0] EV_UP          = 3'd1;
    localparam logic [2:0] EV_LOSS_HIGH   = 3'd2;
    localparam logic [2:0] EV_LOSS_NORMAL = 3'd3;
    localparam logic [2:0] EV_TEMP_HIGH   = 3'd4;
    localparam logic [2:0] EV_TEMP_NORMAL = 3'd5;
    localparam logic [2:0] EV_SUMMARY     = 3'd6;

    // register map
    localparam int          ADDR_W        = 3;
    localparam logic [2:0]  ADDR_LOSS_THR = 3'd0;
    localparam logic [2:0]  ADDR_TEMP_THR = 3'd4;
    localparam logic [6:0]  LOSS_THR_RST  = 7'd5;
    localparam logic [6:0]  TEMP_THR_RST  = 7'd80;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 80;
    localparam int MAX_EV   = 3;

    typedef struct packed {
        logic       opcode;
        logic [1:0] link_state;
        logic       loss_valid;
        logic [9:0] loss_tenths;
        logic [6:0] temp_pct;
        logic [6:0] cpu_pct;
    } item_t;

    typedef struct packed {
        logic [6:0]         loss_thr;
        logic [6:0]         temp_thr;
    } cfg_t;

    typedef struct packed {
        logic [6:0]         cpu_low;
        logic signed [7:0]  cpu_high;
        logic [6:0]         temp_low;
        logic signed [7:0]  temp_high;
        logic [9:0]         loss_low;
        logic signed [10:0] loss_high;
        logic [15:0]        down_total;
    } stats_t;

    localparam stats_t STATS_CLEAR = '{
        cpu_low:    7'd101,
        cpu_high:   -8'sd1,
        temp_low:   7'd101,
        temp_high:  -8'sd1,
        loss_low:   10'd1023,
        loss_high:  -11'sd1,
        down_total: 16'd0
    };

    // one item's worth of results: up to three events sharing a statistics view
    typedef struct packed {
        logic [1:0]              cnt;
        logic [MAX_EV-1:0][2:0]  ev;
        logic [MAX_EV-1:0][9:0]  val;
        stats_t                  stats;
    } grp_t;

endpackage

`default_nettype wire

[src/tam_cfg.sv]
// ----------------------------------------------------------------------------
// tam_cfg
// APB register file holding the loss and temperature thresholds.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_cfg (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [tam_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    output tam_pkg::cfg_t                  cfg_o
);
    import tam_pkg::*;

    logic [6:0] loss_thr_reg;
    logic [6:0] temp_thr_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_thr_reg <= LOSS_THR_RST;
            temp_thr_reg <= TEMP_THR_RST;
        end else if (wr_en) begin
            if (paddr == ADDR_LOSS_THR) begin
                loss_thr_reg <= pwdata[6:0];
            end
            if (paddr == ADDR_TEMP_THR) begin
                temp_thr_reg <= pwdata[6:0];
            end
        end
    end

    always_comb begin
        case (paddr)
            ADDR_LOSS_THR: prdata = {25'd0, loss_thr_reg};
            ADDR_TEMP_THR: prdata = {25'd0, temp_thr_reg};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg_o.loss_thr = loss_thr_reg;
    assign cfg_o.temp_thr = temp_thr_reg;

endmodule

`default_nettype wire

[src/tam_core.sv]
// ----------------------------------------------------------------------------
// tam_core
// Alert state, running statistics and event generation for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           adv_i,
    input  wire tam_pkg::item_t item_i,
    input  wire tam_pkg::cfg_t  cfg_i,
    output tam_pkg::grp_t       grp_o
);
    import tam_pkg::*;

    stats_t      stats_reg, stats_next;
    logic        have_reg, have_next;
    logic        online_reg, online_next;
    logic        loss_alert_reg, loss_alert_next;
    logic        temp_alert_reg, temp_alert_next;

    logic        online;
    logic        loss_over;
    logic        temp_over;
    logic        temp_ok;
    logic [10:0] loss_limit;
    logic [1:0]  n;

    // threshold times ten as shift and add
    assign loss_limit = {1'b0, cfg_i.loss_thr, 3'b000} + {3'b000, cfg_i.loss_thr, 1'b0};
    assign loss_over  = {1'b0, item_i.loss_tenths} >= loss_limit;
    assign temp_over  = item_i.temp_pct >= cfg_i.temp_thr;
    assign temp_ok    = item_i.temp_pct != 7'd0;
    assign online     = item_i.link_state == LINK_ONLINE;

    always_comb begin
        stats_next      = stats_reg;
        have_next       = have_reg;
        online_next     = online_reg;
        loss_alert_next = loss_alert_reg;
        temp_alert_next = temp_alert_reg;
        grp_o           = '0;
        n               = 2'd0;
        if (item_i.opcode == OP_SUMMARY) begin
            grp_o.cnt    = 2'd1;
            grp_o.ev[0]  = EV_SUMMARY;
            grp_o.stats  = stats_reg;
            stats_next   = STATS_CLEAR;
        end else begin
            if (item_i.link_state == LINK_ONLINE || item_i.link_state == LINK_DOWN) begin
                if (!have_reg || online != online_reg) begin
                    if (!online) begin
                        grp_o.ev[n] = EV_DOWN;
                        n = n + 2'd1;
                        if (stats_reg.down_total != 16'hFFFF) begin
                            stats_next.down_total = stats_reg.down_total + 16'd1;
                        end
                    end else if (have_reg) begin
                        grp_o.ev[n] = EV_UP;
                        n = n + 2'd1;
                    end
                    online_next = online;
                    have_next   = 1'b1;
                end
            end
            if (item_i.loss_valid) begin
                if (loss_over && !loss_alert_reg) begin
                    grp_o.ev[n]  = EV_LOSS_HIGH;
                    grp_o.val[n] = item_i.loss_tenths;
                    n = n + 2'd1;
                end else if (!loss_over && loss_alert_reg) begin
                    grp_o.ev[n]  = EV_LOSS_NORMAL;
                    grp_o.val[n] = item_i.loss_tenths;
                    n = n + 2'd1;
                end
                loss_alert_next = loss_over;
                if (item_i.loss_tenths < stats_reg.loss_low) begin
                    stats_next.loss_low = item_i.loss_tenths;
                end
                if ($signed({1'b0, item_i.loss_tenths}) > stats_reg.loss_high) begin
                    stats_next.loss_high = $signed({1'b0, item_i.loss_tenths});
                end
            end
            if (temp_ok) begin
                if (temp_over && !temp_alert_reg) begin
                    grp_o.ev[n]  = EV_TEMP_HIGH;
                    grp_o.val[n] = {3'b000, item_i.temp_pct};
                    n = n + 2'd1;
                end else if (!temp_over && temp_alert_reg) begin
                    grp_o.ev[n]  = EV_TEMP_NORMAL;
                    grp_o.val[n] = {3'b000, item_i.temp_pct};
                    n = n + 2'd1;
                end
                temp_alert_next = temp_over;
                if (item_i.temp_pct < stats_reg.temp_low) begin
                    stats_next.temp_low = item_i.temp_pct;
                end
                if ($signed({1'b0, item_i.temp_pct}) > stats_reg.temp_high) begin
                    stats_next.temp_high = $signed({1'b0, item_i.temp_pct});
                end
            end
            if (item_i.cpu_pct < stats_reg.cpu_low) begin
                stats_next.cpu_low = item_i.cpu_pct;
            end
            if ($signed({1'b0, item_i.cpu_pct}) > stats_reg.cpu_high) begin
                stats_next.cpu_high = $signed({1'b0, item_i.cpu_pct});
            end
            grp_o.cnt   = n;
            grp_o.stats = stats_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stats_reg      <= STATS_CLEAR;
            have_reg       <= 1'b0;
            online_reg     <= 1'b0;
            loss_alert_reg <= 1'b0;
            temp_alert_reg <= 1'b0;
        end else if (adv_i) begin
            stats_reg      <= stats_next;
            have_reg       <= have_next;
            online_reg     <= online_next;
            loss_alert_reg <= loss_alert_next;
            temp_alert_reg <= temp_alert_next;
        end
    end

    // down count only moves up between summaries
    a_down_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_i && item_i.opcode == OP_SAMPLE |=> stats_reg.down_total >= $past(stats_reg.down_total))
        else $error("down count went backwards on a sample");

    // a summary leaves the statistics at their sentinels
    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        adv_i && item_i.opcode == OP_SUMMARY |=> stats_reg == STATS_CLEAR)
        else $error("statistics not cleared after summary");

endmodule

`default_nettype wire

[src/tam_outq.sv]
// ----------------------------------------------------------------------------
// tam_outq
// Result register: holds the events of one item and hands them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tam_outq (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          load_i,
    input  wire tam_pkg::grp_t                 grp_i,
    output logic                               take_ok_o,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tam_pkg::M_DATA_W-1:0]       m_tdata,  // value, min_cpu_seen,
                                                         // max_cpu_seen, min_temp_seen,
                                                         // max_temp_seen, min_loss_seen,
                                                         // max_loss_seen, down_events, pad
    output logic [2:0]                         m_tuser,  // event_res
    output logic                               m_tlast
);
    import tam_pkg::*;

    logic [1:0]             cnt_reg;
    logic [MAX_EV-1:0][2:0] ev_reg;
    logic [MAX_EV-1:0][9:0] val_reg;
    stats_t                 stats_reg;
    logic                   pop;

    assign pop       = m_tvalid && m_tready;
    // free now, or the final event leaves this cycle
    assign take_ok_o = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load_i) begin
            cnt_reg <= grp_i.cnt;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i) begin
            ev_reg    <= grp_i.ev;
            val_reg   <= grp_i.val;
            stats_reg <= grp_i.stats;
        end else if (pop) begin
            ev_reg    <= {3'd0, ev_reg[2], ev_reg[1]};
            val_reg   <= {10'd0, val_reg[2], val_reg[1]};
        end
    end

    assign m_tvalid = cnt_reg != 2'd0;
    assign m_tlast  = cnt_reg == 2'd1;
    assign m_tuser  = ev_reg[0];
    assign m_tdata  = {3'b000, stats_reg.down_total, stats_reg.loss_high,
                       stats_reg.loss_low, stats_reg.temp_high, stats_reg.temp_low,
                       stats_reg.cpu_high, stats_reg.cpu_low, val_reg[0]};

    // never overwrite events still waiting
    a_no_clobber: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |-> take_ok_o)
        else $error("result group loaded over pending events");

    // a loaded group with events shows up on the next cycle
    a_load_show: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i && grp_i.cnt != 2'd0 |=> m_tvalid && m_tuser == $past(grp_i.ev[0]))
        else $error("loaded group not presented");

    // a summary is always a lone result
    a_sum_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == EV_SUMMARY |-> m_tlast)
        else $error("summary not marked last");

endmodule

`default_nettype wire

[src/threshold_alert_monitor_with_minmax.sv]
// ----------------------------------------------------------------------------
// threshold_alert_monitor_with_minmax
// Link, loss and temperature alert monitor with running min/max statistics.
// ----------------------------------------------------------------------------
// an item is held in item_reg; its results then load the result register
// throughput: one item per cycle while results are accepted; an item
//   with more than one result (up to three) stalls the input while the single
//   result register drains; eventless items are consumed and produce nothing
// reset: synchronous active-low; clears alerts and link history, sets the
//   statistics to their sentinels and thresholds to 5 and 80 percent
`default_nettype none

module threshold_alert_monitor_with_minmax (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tam_pkg::S_DATA_W-1:0]  s_tdata,  // link_state, loss_valid,
                                                         // loss_tenths, temp_pct,
                                                         // cpu_pct, pad
    input  wire logic                          s_tuser,  // opcode
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tam_pkg::M_DATA_W-1:0]       m_tdata,  // value, min_cpu_seen,
                                                         // max_cpu_seen, min_temp_seen,
                                                         // max_temp_seen, min_loss_seen,
                                                         // max_loss_seen, down_events, pad
    output logic [2:0]                         m_tuser,  // event_res
    output logic                               m_tlast,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tam_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import tam_pkg::*;

    cfg_t   cfg;
    item_t  item_reg;
    item_t  item_in;
    logic   in_valid_reg;
    logic   take_ok;
    logic   adv;
    grp_t   grp;

    assign item_in.opcode      = s_tuser;
    assign item_in.link_state  = s_tdata[1:0];
    assign item_in.loss_valid  = s_tdata[2];
    assign item_in.loss_tenths = s_tdata[12:3];
    assign item_in.temp_pct    = s_tdata[19:13];
    assign item_in.cpu_pct     = s_tdata[26:20];

    assign adv      = in_valid_reg && take_ok;
    assign s_tready = !in_valid_reg || take_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_in;
        end
    end

    tam_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    tam_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv_i   (adv),
        .item_i  (item_reg),
        .cfg_i   (cfg),
        .grp_o   (grp)
    );

    tam_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_i    (adv),
        .grp_i     (grp),
        .take_ok_o (take_ok),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a held item that cannot move stays held
    a_hold_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !take_ok |=> in_valid_reg && $stable(item_reg))
        else $error("stalled input item lost");

endmodule

`default_nettype wire
